// ===== rtl/plr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plr_pkg: shared types and constants
// Widths, operation and status codes, and the word broadcast to every cell.
// ----------------------------------------------------------------------------
package plr_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int CNTO_W   = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command seen by all cells in the cycle a word is accepted
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             wr;
        logic [CMP_W-1:0] pos;
        logic [CMP_W-1:0] cnt;
    } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/plr_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plr_cell: one list slot
// Holds one element and picks, from its own index, whether to take the left
// neighbor, the right neighbor, the new value, or hold.
// ----------------------------------------------------------------------------
module plr_cell
    import plr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [IDX_W-1:0]        idx,
    input  wire cell_cmd_t               cmd,
    input  wire logic signed [VAL_W-1:0] left_val,
    input  wire logic signed [VAL_W-1:0] right_val,
    input  wire logic signed [VAL_W-1:0] load_val,
    output logic signed [VAL_W-1:0]      val
);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic [CMP_W-1:0]        idx_ext;
    logic [CMP_W-1:0]        idx_inc;

    assign idx_ext = CMP_W'(idx);
    assign idx_inc = idx_ext + CMP_W'(1);

    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins && (idx_ext > cmd.pos) && (idx_ext <= cmd.cnt))
        begin
            val_next = left_val;
        end
        else if ((cmd.ins || cmd.wr) && (idx_ext == cmd.pos))
        begin
            val_next = load_val;
        end
        else if (cmd.rem && (idx_ext >= cmd.pos) && (idx_inc < cmd.cnt))
        begin
            // close the gap left by the removed entry
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule
`default_nettype wire

// ===== rtl/positional_insert_remove_list_top.sv =====
`default_nettype none
// A result appears with done in the cycle after start is taken.
// Throughput: one word per cycle; busy stays low, and every cell updates together.
// The read and remove paths select one of CAPACITY cells through an AND-OR tree.
// Reset clears the count and the output strobe; element storage is not cleared.
// Results are shown for a single cycle and cannot be held off.
// ----------------------------------------------------------------------------
// positional_insert_remove_list_top: ordered list in a row of cells
// Insert, remove, read and write at a position; range and full checks.
// ----------------------------------------------------------------------------
module positional_insert_remove_list_top
    import plr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              op,
    input  wire logic [POS_W-1:0]        position,
    input  wire logic signed [VAL_W-1:0] value,
    output logic                         done,
    output logic signed [VAL_W-1:0]      value_out,
    output logic [1:0]                   status,
    output logic [CNTO_W-1:0]            count
);

    logic                    accept;
    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic                    range_err;
    logic                    full_err;
    logic                    op_ok;
    logic signed [VAL_W-1:0] rd_val;
    cell_cmd_t               cmd;

    logic signed [VAL_W-1:0] cell_val [CAPACITY];

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    done_reg;
    logic signed [VAL_W-1:0] value_out_reg;
    logic signed [VAL_W-1:0] value_out_next;
    status_t                 status_reg;
    status_t                 status_next;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb
    begin
        range_err = 1'b0;
        full_err  = 1'b0;
        case (op_t'(op))
            OP_INSERT:
            begin
                range_err = pos_ext > cnt_ext;
                full_err  = !range_err && (cnt_ext == CMP_W'(CAPACITY));
            end
            OP_REMOVE, OP_READ, OP_WRITE:
            begin
                range_err = pos_ext >= cnt_ext;
            end
            default:
            begin
                range_err = 1'b1;
            end
        endcase
    end

    assign op_ok   = accept && !range_err && !full_err;
    assign cmd.ins = op_ok && (op_t'(op) == OP_INSERT);
    assign cmd.rem = op_ok && (op_t'(op) == OP_REMOVE);
    assign cmd.wr  = op_ok && (op_t'(op) == OP_WRITE);
    assign cmd.pos = pos_ext;
    assign cmd.cnt = cnt_ext;

    // select the entry at position before the cells move
    always_comb
    begin
        rd_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CMP_W'(i) == pos_ext)
            begin
                rd_val = rd_val | cell_val[i];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_w;
        logic signed [VAL_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_val[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_val[g+1];
        end

        plr_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(g)),
            .cmd       (cmd),
            .left_val  (left_w),
            .right_val (right_w),
            .load_val  (value),
            .val       (cell_val[g])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        value_out_next = '0;
        status_next    = ST_OK;
        if (range_err)
        begin
            status_next = ST_RANGE;
        end
        else if (full_err)
        begin
            status_next = ST_FULL;
        end
        else if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            count_next     = count_reg - CNT_W'(1);
            value_out_next = rd_val;
        end
        else if (op_t'(op) == OP_READ)
        begin
            value_out_next = rd_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_out_reg <= value_out_next;
            status_reg    <= status_next;
        end
    end

    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign count     = CNTO_W'(count_reg);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rem |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not shrink the list");

    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (range_err || full_err)) |=>
            ($stable(count_reg) && (value_out_reg == '0)))
        else $error("failed operation changed state or returned data");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg)
        else $error("accepted word produced no result");
`endif

endmodule
`default_nettype wire

// ===== dv/plr_list_checker.sv =====
// ----------------------------------------------------------------------------
// plr_list_checker: result checker for the positional insert/remove list
// Watches the command and result channels. It keeps its own copy of the list,
// works out the reply to every accepted word and compares replies in order.
// ----------------------------------------------------------------------------
module plr_list_checker
    import plr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [1:0]              op,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    done,
    input  logic signed [VAL_W-1:0] value_out,
    input  logic [1:0]              status,
    input  logic [CNTO_W-1:0]       count,
    output int unsigned             mismatches,
    output int unsigned             outstanding,
    output int unsigned             replies_checked,
    output int unsigned             range_refusals,
    output int unsigned             full_refusals
);

    localparam int unsigned REPLY_DEPTH = 16;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        status_t                 status;
        logic [CNTO_W-1:0]       count;
    } list_reply_t;

    list_reply_t             reply_fifo[REPLY_DEPTH];
    int unsigned             fifo_rd;
    int unsigned             fifo_wr;
    int unsigned             fifo_fill;
    logic signed [VAL_W-1:0] list_cells[CAPACITY];
    int unsigned             list_len;
    int unsigned             bad_words;
    int unsigned             n_checked;
    int unsigned             n_range;
    int unsigned             n_full;
    list_reply_t             got_reply;
    list_reply_t             want_reply;

    // Apply one operation to the list copy and return the reply it gives
    function automatic list_reply_t apply_list_op(op_t o, int unsigned pos,
                                                  logic signed [VAL_W-1:0] v);
        list_reply_t r;
        int          i;
        r.value  = '0;
        r.status = ST_OK;
        if (o == OP_INSERT) begin
            // position check wins over the full check
            if (pos > list_len) begin
                r.status = ST_RANGE;
            end
            else if (list_len >= CAPACITY) begin
                r.status = ST_FULL;
            end
            else begin
                for (i = int'(list_len); i > int'(pos); i--)
                    list_cells[i] = list_cells[i-1];
                list_cells[pos] = v;
                list_len++;
            end
        end
        else if (pos >= list_len) begin
            r.status = ST_RANGE;
        end
        else begin
            case (o)
                OP_REMOVE:
                begin
                    r.value = list_cells[pos];
                    list_len--;
                    for (i = int'(pos); i < int'(list_len); i++)
                        list_cells[i] = list_cells[i+1];
                end
                OP_READ:
                begin
                    r.value = list_cells[pos];
                end
                default:
                begin
                    list_cells[pos] = v;
                end
            endcase
        end
        r.count = CNTO_W'(list_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fifo_rd         = 0;
            fifo_wr         = 0;
            fifo_fill       = 0;
            list_len        = 0;
            bad_words       = 0;
            n_checked       = 0;
            n_range         = 0;
            n_full          = 0;
            mismatches      <= 0;
            outstanding     <= 0;
            replies_checked <= 0;
            range_refusals  <= 0;
            full_refusals   <= 0;
        end
        else begin
            if (done) begin
                got_reply = '{value: value_out, status: status_t'(status), count: count};
                if (fifo_fill == 0) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display({"%0t: result with nothing pending: ",
                                  "value %0d status %0d count %0d"},
                                 $realtime, value_out, status, count);
                end
                else begin
                    want_reply = reply_fifo[fifo_rd];
                    fifo_rd    = (fifo_rd + 1) % REPLY_DEPTH;
                    fifo_fill--;
                    n_checked++;
                    if (got_reply.value !== want_reply.value ||
                        got_reply.status !== want_reply.status ||
                        got_reply.count !== want_reply.count) begin
                        bad_words++;
                        if (bad_words <= 10)
                            $display({"%0t: reply %0d: want value %0d status %0d ",
                                      "count %0d, got value %0d status %0d count %0d"},
                                     $realtime, n_checked, want_reply.value,
                                     want_reply.status, want_reply.count,
                                     value_out, status, count);
                    end
                end
            end
            if (start && !busy) begin
                want_reply = apply_list_op(op_t'(op), int'(position), value);
                if (want_reply.status == ST_RANGE)
                    n_range++;
                if (want_reply.status == ST_FULL)
                    n_full++;
                if (fifo_fill == REPLY_DEPTH) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("%0t: too many replies pending", $realtime);
                end
                else begin
                    reply_fifo[fifo_wr] = want_reply;
                    fifo_wr             = (fifo_wr + 1) % REPLY_DEPTH;
                    fifo_fill++;
                end
            end
            mismatches      <= bad_words;
            outstanding     <= fifo_fill;
            replies_checked <= n_checked;
            range_refusals  <= n_range;
            full_refusals   <= n_full;
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the positional insert/remove list
// Directed corner words, then bursts of random list operations that fill,
// drain and churn the list; replies are checked by plr_list_checker.
// ----------------------------------------------------------------------------
module tb;
    import plr_pkg::*;

    localparam int unsigned RANDOM_WORDS   = 1950;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    op_t                     op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    done;
    logic signed [VAL_W-1:0] value_out;
    logic [1:0]              status;
    logic [CNTO_W-1:0]       count;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned replies_checked;
    int unsigned range_refusals;
    int unsigned full_refusals;

    int unsigned fill_level;
    int unsigned words_sent;
    int unsigned stall_cycles;
    int unsigned peak_fill;

    positional_insert_remove_list_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .position  (position),
        .value     (value),
        .done      (done),
        .value_out (value_out),
        .status    (status),
        .count     (count)
    );

    plr_list_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .position        (position),
        .value           (value),
        .done            (done),
        .value_out       (value_out),
        .status          (status),
        .count           (count),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .replies_checked (replies_checked),
        .range_refusals  (range_refusals),
        .full_refusals   (full_refusals)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold start high until the word is taken; track list length for stimulus
    task automatic send_word(op_t o, int unsigned pos, logic signed [VAL_W-1:0] v);
        start    <= 1'b1;
        op       <= o;
        position <= POS_W'(pos);
        value    <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (o == OP_INSERT && pos <= fill_level && fill_level < CAPACITY)
            fill_level++;
        else if (o == OP_REMOVE && pos < fill_level)
            fill_level--;
        if (fill_level > peak_fill)
            peak_fill = fill_level;
    endtask

    task automatic pause_sender(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_replies();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions, biased toward the ends, with some random noise
    function automatic int unsigned pick_position(op_t o);
        int unsigned top_pos;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, CAPACITY);
        if (o == OP_INSERT)
            top_pos = fill_level;
        else if (fill_level == 0)
            return 0;
        else
            top_pos = fill_level - 1;
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return top_pos;
            default: return $urandom_range(0, top_pos);
        endcase
    endfunction

    function automatic op_t pick_op(int unsigned mode);
        int unsigned roll;
        int unsigned ins_w;
        int unsigned rem_w;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       begin ins_w = 60; rem_w = 10; end
            1:       begin ins_w = 10; rem_w = 60; end
            default: begin ins_w = 30; rem_w = 30; end
        endcase
        if (roll < ins_w)
            return OP_INSERT;
        if (roll < ins_w + rem_w)
            return OP_REMOVE;
        if (roll < ins_w + rem_w + (100 - ins_w - rem_w) / 2)
            return OP_READ;
        return OP_WRITE;
    endfunction

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        int unsigned burst_len;
        int unsigned mode;
        op_t         o;
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = OP_INSERT;
        position   = '0;
        value      = '0;
        fill_level = 0;
        words_sent = 0;
        peak_fill  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every access is out of range
        send_word(OP_REMOVE, 0, 32'sd5);
        send_word(OP_READ, 0, 32'sd0);
        send_word(OP_WRITE, 0, 32'sd77);
        send_word(OP_INSERT, 1, 32'sd9);
        // build [-1, 0, min, max] through front, back and middle inserts
        send_word(OP_INSERT, 0, 32'sh8000_0000);
        send_word(OP_INSERT, 1, 32'sh7fff_ffff);
        send_word(OP_INSERT, 0, -32'sd1);
        send_word(OP_INSERT, 1, 32'sd0);
        send_word(OP_INSERT, 5, 32'sd3);
        for (int p = 0; p < 4; p++)
            send_word(OP_READ, p, $urandom);
        send_word(OP_READ, 4, 32'sd0);
        send_word(OP_WRITE, 2, 32'sh5a5a_5a5a);
        send_word(OP_WRITE, 4, 32'sd1);
        send_word(OP_READ, 2, 32'sd0);
        send_word(OP_REMOVE, 1, 32'sd0);
        send_word(OP_REMOVE, 0, 32'sd0);
        send_word(OP_REMOVE, fill_level - 1, 32'sd0);
        send_word(OP_REMOVE, 3, 32'sd0);
        send_word(OP_INSERT, CAPACITY, 32'sd0);
        wait_replies();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            burst_len = $urandom_range(1, 40);
            mode      = $urandom_range(0, 2);
            for (int k = 0; k < burst_len; k++) begin
                o = pick_op(mode);
                send_word(o, pick_position(o), pick_value());
            end
            if ($urandom_range(0, 29) == 0)
                wait_replies();
            else if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end

        wait_replies();
        repeat (4) @(posedge clk);
        $display("sent %0d random words after the directed set; %0d replies checked",
                 words_sent, replies_checked);
        $display("range refusals %0d, full-list refusals %0d, deepest list %0d entries",
                 range_refusals, full_refusals, peak_fill);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/plr_pkg.sv
rtl/plr_cell.sv
rtl/positional_insert_remove_list_top.sv
dv/plr_list_checker.sv
dv/tb.sv
